// ===== hdl/urx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants of the serial receiver with receive buffer.
// ----------------------------------------------------------------------------
package urx_pkg;

  // Receive buffer geometry
  localparam int RX_DEPTH  = 64;
  localparam int PTR_W     = $clog2(RX_DEPTH);
  localparam int HELD_W    = 6;

  // Field widths
  localparam int TIME_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Item commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_PERIOD   = 2'd0,
    REG_FIRST_SAMPLE = 2'd1,
    REG_LAST_SAMPLE  = 2'd2,
    REG_RX_ENABLE    = 2'd3
  } cfg_reg_t;

  // Result word waiting for buffer read data
  typedef struct packed {
    logic              data_valid;
    logic [HELD_W-1:0] bytes_held;
    logic              overflow;
    logic              receiving;
    logic              byte_stored;
  } result_t;

endpackage : urx_pkg
`default_nettype wire

// ===== hdl/urx_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urx_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module urx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : urx_ram
`default_nettype wire

// ===== hdl/uart_receiver_with_rx_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_receiver_with_rx_fifo
// 8N1 serial receiver fed by line samples, with a ring buffer of bytes.
// ----------------------------------------------------------------------------
// The block takes one word per clock: a tick with a line sample, a read, a
// peek or a flush, and returns one result word for each. The clock edge that
// accepts a word loads the registered read of the buffer RAM and the result
// stage; the result then moves into the output register and is valid on the
// output from there. The RAM has one write port (received bytes at the tail)
// and one read port (the head), so a tick and a read never compete and the
// rate stays one word per clock. When the output is held, up to two result
// words wait and then the input is held too. The buffer holds up to 63
// bytes; a byte completed on a full buffer is dropped and sets a sticky
// overflow flag. Configuration writes are taken any time and should be
// made while the block is idle.
// ----------------------------------------------------------------------------
module uart_receiver_with_rx_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input words
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic [7:0]                      s_tdata,  // [0] line_level
  input  wire logic [1:0]                      s_tuser,  // [1:0] command
  // Result words
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] data, [13:8] bytes_held, [14] overflow, [15] receiving,
  // [16] byte_stored
  output      logic [23:0]                     m_tdata,
  output      logic                            m_tuser,  // [0] data_valid
  // Configuration
  input  wire logic                            cfg_we,
  input  wire logic [urx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [urx_pkg::CFG_W-1:0]       cfg_data
);

  import urx_pkg::*;

  // Configuration registers
  logic [TIME_W-1:0] bit_period;
  logic [TIME_W-1:0] first_sample_delay;
  logic [TIME_W-1:0] last_sample_delay;
  logic              rx_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period         <= TIME_W'(16);
      first_sample_delay <= TIME_W'(24);
      last_sample_delay  <= TIME_W'(136);
      rx_enable          <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIT_PERIOD:   bit_period         <= cfg_data;
        REG_FIRST_SAMPLE: first_sample_delay <= cfg_data;
        REG_LAST_SAMPLE:  last_sample_delay  <= cfg_data;
        REG_RX_ENABLE:    rx_enable          <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Receiver and buffer control state
  logic              previous_line, previous_line_next;
  logic              busy, busy_next;
  logic [TIME_W-1:0] ticks, ticks_next;
  logic [TIME_W-1:0] sample_time, sample_time_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic              overflow_flag, overflow_flag_next;

  // Pipeline: stage 1 waits on RAM read data, then the output register
  logic    s1_valid;
  result_t s1_res;
  logic    out_valid;
  logic    advance;
  logic    accept;

  cmd_t              cmd;
  logic              line;
  logic [TIME_W-1:0] ticks_inc;
  logic [TIME_W-1:0] step;
  logic [TIME_W:0]   sum;
  logic              hit;
  logic              finish;
  logic              full;
  logic              push;
  logic              rd_en;
  logic              data_valid;
  logic [BYTE_W-1:0] rd_data;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser);
  assign line     = s_tdata[0];

  // Sample timing arithmetic
  assign ticks_inc = (ticks == TIME_MAX) ? ticks : ticks + TIME_W'(1);
  assign step      = (bit_period == '0) ? TIME_W'(1) : bit_period;
  assign sum       = {1'b0, sample_time} + {1'b0, step};
  assign hit       = (ticks_inc > sample_time) ||
                     (ticks_inc == TIME_MAX && sample_time == TIME_MAX);
  assign full      = (tail + PTR_W'(1)) == head;

  // Next state of the receiver and the buffer pointers
  always_comb begin
    previous_line_next = previous_line;
    busy_next          = busy;
    ticks_next         = ticks;
    sample_time_next   = sample_time;
    shift_byte_next    = shift_byte;
    head_next          = head;
    tail_next          = tail;
    overflow_flag_next = overflow_flag;
    finish             = 1'b0;
    push               = 1'b0;
    rd_en              = 1'b0;
    data_valid         = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (busy) begin
          ticks_next = ticks_inc;
          if (hit) begin
            shift_byte_next = {line, shift_byte[BYTE_W-1:1]};
            if (sum[TIME_W]) begin
              finish           = 1'b1;
              sample_time_next = TIME_MAX;
            end else begin
              sample_time_next = sum[TIME_W-1:0];
              finish           = sum[TIME_W-1:0] > last_sample_delay;
            end
          end
        end else if (rx_enable && previous_line && !line) begin
          busy_next        = 1'b1;
          ticks_next       = '0;
          sample_time_next = first_sample_delay;
          shift_byte_next  = '0;
          finish           = first_sample_delay > last_sample_delay;
        end
        if (finish) begin
          busy_next = 1'b0;
          if (full) begin
            overflow_flag_next = 1'b1;
          end else begin
            push      = 1'b1;
            tail_next = tail + PTR_W'(1);
          end
        end
        previous_line_next = line;
      end
      CMD_READ, CMD_PEEK: begin
        if (head != tail) begin
          rd_en      = 1'b1;
          data_valid = 1'b1;
          if (cmd == CMD_READ) begin
            head_next = head + PTR_W'(1);
          end
        end
      end
      CMD_FLUSH: begin
        tail_next = head;
      end
      default: ;
    endcase
  end

  // Update state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_line <= 1'b1;
      busy          <= 1'b0;
      ticks         <= '0;
      sample_time   <= '0;
      shift_byte    <= '0;
      head          <= '0;
      tail          <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      previous_line <= previous_line_next;
      busy          <= busy_next;
      ticks         <= ticks_next;
      sample_time   <= sample_time_next;
      shift_byte    <= shift_byte_next;
      head          <= head_next;
      tail          <= tail_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  // Byte buffer: push at tail, read at head
  urx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (accept && push),
    .waddr (tail),
    .wdata (shift_byte_next),
    .re    (accept && rd_en),
    .raddr (head),
    .rdata (rd_data)
  );

  // Stage 1: hold result while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res.data_valid  <= data_valid;
      s1_res.bytes_held  <= HELD_W'(tail_next - head_next);
      s1_res.overflow    <= overflow_flag_next;
      s1_res.receiving   <= busy_next;
      s1_res.byte_stored <= push;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= {7'd0, s1_res.byte_stored, s1_res.receiving, s1_res.overflow,
                  s1_res.bytes_held, s1_res.data_valid ? rd_data : 8'd0};
      m_tuser <= s1_res.data_valid;
    end
  end

  assign m_tvalid = out_valid;

  // Checks
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag)
    else $error("overflow flag cleared");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    (accept && push) |-> !full)
    else $error("byte pushed into a full buffer");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && push) |=> (tail - head) == $past(tail - head) + PTR_W'(1))
    else $error("buffer count did not grow on push");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=>
      (s1_valid && $stable(s1_res) && (!s1_res.data_valid || $stable(rd_data))))
    else $error("stalled result or read data changed");

endmodule : uart_receiver_with_rx_fifo
`default_nettype wire
